@@ design/irc_colour_code_stripper_assert.svh @@
// Assertion macros shared by the colour-code stripper modules.
`ifndef IRC_COLOUR_CODE_STRIPPER_ASSERT_SVH
`define IRC_COLOUR_CODE_STRIPPER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IRCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IRCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ircs_pkg.sv @@
`timescale 1ns / 1ps

package ircs_pkg;

  // Default width of the position counter
  localparam int POSITION_BITS_DEF = 16;
  // Width of the position field on the result channel
  localparam int OUT_POS_BITS = 16;
  // Most results one input beat can cause
  localparam int RES_MAX = 3;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Parser phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TILDE = 3'd1;
  localparam logic [2:0] PH_CTRL  = 3'd2;
  localparam logic [2:0] PH_DIG1  = 3'd3;
  localparam logic [2:0] PH_DIG2  = 3'd4;
  localparam logic [2:0] PH_COMMA = 3'd5;
  localparam logic [2:0] PH_CDIG1 = 3'd6;

  // Characters of interest
  localparam logic [7:0] CH_CTRL   = 8'h03;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;

  typedef struct packed {
    logic       tilde_held;
    logic [2:0] phase;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]              ch;
    logic [OUT_POS_BITS-1:0] pos;
    logic                    has_char;
    logic                    last;
  } res_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_DIG_LO) && (c <= CH_DIG_HI);
  endfunction

  function automatic logic is_format_letter(logic [7:0] c);
    return (c == 8'h62) || (c == 8'h75) || (c == 8'h72) || (c == 8'h73) ||
           (c == 8'h63) || (c == 8'h69) || (c == 8'h43);
  endfunction

endpackage

@@ design/ircs_step.sv @@
`timescale 1ns / 1ps

module ircs_step #(
  parameter int POSITION_BITS = ircs_pkg::POSITION_BITS_DEF
) (
  input  ircs_pkg::parse_state_t                    st_cur,
  input  logic [POSITION_BITS-1:0]                  held_pos_cur,
  input  logic [POSITION_BITS-1:0]                  pos_cnt_cur,
  input  logic [7:0]                                in_byte,
  input  logic                                      in_last,
  output ircs_pkg::parse_state_t                    st_nxt,
  output logic [POSITION_BITS-1:0]                  held_pos_nxt,
  output logic [POSITION_BITS-1:0]                  pos_cnt_nxt,
  output ircs_pkg::res_t [ircs_pkg::RES_MAX-1:0]    res,
  output logic [1:0]                                res_num
);

  localparam int P   = POSITION_BITS;
  localparam int OPB = ircs_pkg::OUT_POS_BITS;
  localparam logic [P-1:0] POS_TOP = '1;
  localparam int NCAND = 5;

  typedef struct packed {
    logic [2:0]   phase;
    logic [P-1:0] held;
    logic [P-1:0] cnt;
    logic [1:0]   em_valid;
    logic [7:0]   em0_ch;
    logic [P-1:0] em0_pos;
    logic [7:0]   em1_ch;
    logic [P-1:0] em1_pos;
  } feed_t;

  // One parser step on one character: the phase arm may emit a held
  // character, then the character may be parsed anew from idle.
  function automatic feed_t feed(logic [2:0] ph, logic [P-1:0] held,
                                 logic [P-1:0] cnt, logic [7:0] c);
    feed_t f;
    logic  to_idle;
    f         = '0;
    f.phase   = ph;
    f.held    = held;
    f.cnt     = (cnt != POS_TOP) ? cnt + 1'b1 : cnt;
    to_idle   = 1'b0;
    unique case (ph) inside
      ircs_pkg::PH_TILDE: begin
        if (ircs_pkg::is_digit(c)) f.phase = ircs_pkg::PH_DIG1;
        else if (ircs_pkg::is_format_letter(c)) f.phase = ircs_pkg::PH_IDLE;
        else to_idle = 1'b1;
      end
      ircs_pkg::PH_CTRL: begin
        if (ircs_pkg::is_digit(c)) begin
          f.phase = ircs_pkg::PH_DIG1;
        end else begin
          f.em_valid[0] = 1'b1;
          f.em0_ch      = ircs_pkg::CH_CTRL;
          f.em0_pos     = held;
          to_idle       = 1'b1;
        end
      end
      ircs_pkg::PH_DIG1, ircs_pkg::PH_DIG2: begin
        if (ph == ircs_pkg::PH_DIG1 && ircs_pkg::is_digit(c)) begin
          f.phase = ircs_pkg::PH_DIG2;
        end else if (c == ircs_pkg::CH_COMMA) begin
          f.phase = ircs_pkg::PH_COMMA;
          f.held  = cnt;
        end else begin
          to_idle = 1'b1;
        end
      end
      ircs_pkg::PH_COMMA: begin
        if (ircs_pkg::is_digit(c)) begin
          f.phase = ircs_pkg::PH_CDIG1;
        end else begin
          f.em_valid[0] = 1'b1;
          f.em0_ch      = ircs_pkg::CH_COMMA;
          f.em0_pos     = held;
          to_idle       = 1'b1;
        end
      end
      ircs_pkg::PH_CDIG1: begin
        if (ircs_pkg::is_digit(c)) f.phase = ircs_pkg::PH_IDLE;
        else to_idle = 1'b1;
      end
      default: to_idle = 1'b1;
    endcase
    if (to_idle) begin
      if (c == ircs_pkg::CH_TILDE) begin
        f.phase = ircs_pkg::PH_TILDE;
        f.held  = cnt;
      end else if (c == ircs_pkg::CH_CTRL) begin
        f.phase = ircs_pkg::PH_CTRL;
        f.held  = cnt;
      end else begin
        f.phase       = ircs_pkg::PH_IDLE;
        f.em_valid[1] = 1'b1;
        f.em1_ch      = c;
        f.em1_pos     = cnt;
      end
    end
    return f;
  endfunction

  logic                 en1, en2, is_s, is_tilde, fl_valid;
  logic [7:0]           c1;
  feed_t                f1, f2, mid;
  logic [2:0]           ph_end;
  logic [P-1:0]         held_end, cnt_end;
  logic [NCAND-1:0]     cand_v;
  ircs_pkg::res_t [NCAND-1:0] cand;
  logic [1:0]           n;

  // Front stage: "~s" removal decides which characters reach the parser
  assign is_s     = (in_byte == ircs_pkg::CH_S);
  assign is_tilde = (in_byte == ircs_pkg::CH_TILDE);
  assign en1      = st_cur.tilde_held ? !is_s : !is_tilde;
  assign c1       = st_cur.tilde_held ? ircs_pkg::CH_TILDE : in_byte;
  assign en2      = (st_cur.tilde_held && !is_s && !is_tilde) || (in_last && is_tilde);

  // Two chained parser steps
  always_comb begin
    f1 = feed(st_cur.phase, held_pos_cur, pos_cnt_cur, c1);
    if (en1) begin
      mid = f1;
    end else begin
      mid       = '0;
      mid.phase = st_cur.phase;
      mid.held  = held_pos_cur;
      mid.cnt   = pos_cnt_cur;
    end
    f2 = feed(mid.phase, mid.held, mid.cnt, in_byte);
    if (en2) begin
      ph_end   = f2.phase;
      held_end = f2.held;
      cnt_end  = f2.cnt;
    end else begin
      ph_end   = mid.phase;
      held_end = mid.held;
      cnt_end  = mid.cnt;
    end
  end

  // Flush a pending control byte or comma at end of text
  assign fl_valid = in_last &&
                    (ph_end == ircs_pkg::PH_CTRL || ph_end == ircs_pkg::PH_COMMA);

  // Gather candidate results in emission order
  always_comb begin
    cand_v[0] = en1 && f1.em_valid[0];
    cand_v[1] = en1 && f1.em_valid[1];
    cand_v[2] = en2 && f2.em_valid[0];
    cand_v[3] = en2 && f2.em_valid[1];
    cand_v[4] = fl_valid;
    cand[0]   = '{ch: f1.em0_ch, pos: OPB'(f1.em0_pos), has_char: 1'b1, last: 1'b0};
    cand[1]   = '{ch: f1.em1_ch, pos: OPB'(f1.em1_pos), has_char: 1'b1, last: 1'b0};
    cand[2]   = '{ch: f2.em0_ch, pos: OPB'(f2.em0_pos), has_char: 1'b1, last: 1'b0};
    cand[3]   = '{ch: f2.em1_ch, pos: OPB'(f2.em1_pos), has_char: 1'b1, last: 1'b0};
    cand[4]   = '{ch: (ph_end == ircs_pkg::PH_CTRL) ? ircs_pkg::CH_CTRL : ircs_pkg::CH_COMMA,
                  pos: OPB'(held_end), has_char: 1'b1, last: 1'b0};
  end

  // Pack valid candidates, add the bare end marker, tag the final result
  always_comb begin
    res = '0;
    n   = 2'd0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_v[i] && n != 2'd3) begin
        res[n] = cand[i];
        n      = n + 2'd1;
      end
    end
    if (in_last && n == 2'd0) begin
      res[0] = '0;
      n      = 2'd1;
    end
    if (in_last) res[n - 2'd1].last = 1'b1;
    res_num = n;
  end

  // Next state; end of text returns everything to reset
  always_comb begin
    if (in_last) begin
      st_nxt       = '{tilde_held: 1'b0, phase: ircs_pkg::PH_IDLE};
      held_pos_nxt = '0;
      pos_cnt_nxt  = '0;
    end else begin
      st_nxt       = '{tilde_held: is_tilde, phase: ph_end};
      held_pos_nxt = held_end;
      pos_cnt_nxt  = cnt_end;
    end
  end

endmodule

@@ design/ircs_out_fifo.sv @@
`timescale 1ns / 1ps
`include "irc_colour_code_stripper_assert.svh"

module ircs_out_fifo (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  logic [1:0]                             push_num,
  input  ircs_pkg::res_t [ircs_pkg::RES_MAX-1:0] push_data,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output ircs_pkg::res_t                         head,
  output logic                                   space_ok
);

  localparam int AW    = ircs_pkg::FIFO_AW;
  localparam int CW    = ircs_pkg::FIFO_CW;
  localparam int DEPTH = ircs_pkg::FIFO_DEPTH;

  ircs_pkg::res_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  push_cnt;
  logic           pop;

  // Pop on an output beat; room for a full burst once the pop is counted
  assign pop       = (count_r != '0) && !out_stall;
  assign out_valid = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign space_ok  = (count_r <= CW'(1)) || (count_r == CW'(2) && pop);
  assign push_cnt  = push ? CW'(push_num) : '0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    count_nxt  = count_r + push_cnt - CW'(pop);
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write the burst into consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < ircs_pkg::RES_MAX; i++) begin
      if (push && i < int'(push_num)) mem_r[wr_ptr_r + AW'(i)] <= push_data[i];
    end
  end

  `IRCS_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "fifo overfilled")
  `IRCS_ASSERT_IMP(a_push_fits, clk, rst_n, push, (count_r - CW'(pop)) + push_cnt <= CW'(DEPTH), "push without room")
  `IRCS_ASSERT_NXT(a_push_shows, clk, rst_n, push && push_num != 2'd0, count_r != '0, "pushed beat not visible")

endmodule

@@ design/irc_colour_code_stripper.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_byte, in_last
// out_      output     out_valid/out_stall out_byte, out_position, out_has_char, out_last
//
// All parsing is done in the accept cycle and the up to three results land in a 4-entry
// result queue, drained at one beat per cycle while out_stall is low. From an empty
// queue, a beat's first result is on out_ the cycle after accept. Sustained input rate
// is one beat per cycle while each beat yields at most one result and out_stall is low.
// in_stall rises while the queue cannot take a full burst of three after this cycle's pop.
// Synchronous active-low reset clears the parser state and empties the queue.
`include "irc_colour_code_stripper_assert.svh"

module irc_colour_code_stripper #(
  parameter int POSITION_BITS = ircs_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [ircs_pkg::OUT_POS_BITS-1:0] out_position,
  output logic        out_has_char,
  output logic        out_last
);

  ircs_pkg::parse_state_t                 st_r, st_nxt;
  logic [POSITION_BITS-1:0]               held_pos_r, held_pos_nxt;
  logic [POSITION_BITS-1:0]               pos_cnt_r, pos_cnt_nxt;
  ircs_pkg::res_t [ircs_pkg::RES_MAX-1:0] res;
  logic [1:0]                             res_num;
  ircs_pkg::res_t                         head;
  logic                                   space_ok;
  logic                                   accept;

  assign in_stall = !space_ok;
  assign accept   = in_valid && space_ok;

  // Parse one beat
  ircs_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .st_cur      (st_r),
    .held_pos_cur(held_pos_r),
    .pos_cnt_cur (pos_cnt_r),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .st_nxt      (st_nxt),
    .held_pos_nxt(held_pos_nxt),
    .pos_cnt_nxt (pos_cnt_nxt),
    .res         (res),
    .res_num     (res_num)
  );

  // Advance parser state on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '{tilde_held: 1'b0, phase: ircs_pkg::PH_IDLE};
      held_pos_r <= '0;
      pos_cnt_r  <= '0;
    end else if (accept) begin
      st_r       <= st_nxt;
      held_pos_r <= held_pos_nxt;
      pos_cnt_r  <= pos_cnt_nxt;
    end
  end

  // Queue the results
  ircs_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_num (res_num),
    .push_data(res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .head     (head),
    .space_ok (space_ok)
  );

  assign out_byte     = head.ch;
  assign out_position = head.pos;
  assign out_has_char = head.has_char;
  assign out_last     = head.last;

  `IRCS_ASSERT_NXT(a_last_clears, clk, rst_n, accept && in_last,
                   !st_r.tilde_held && st_r.phase == ircs_pkg::PH_IDLE && pos_cnt_r == '0,
                   "state not cleared after last beat")
  `IRCS_ASSERT_IMP(a_bare_is_last, clk, rst_n, out_valid && !out_has_char, out_last,
                   "bare result without last")
  `IRCS_ASSERT_IMP(a_bare_is_zero, clk, rst_n, out_valid && !out_has_char,
                   out_byte == 8'h00 && out_position == '0, "bare result carries data")

endmodule

@@ verif/tb_irc_colour_code_stripper.sv @@
`timescale 1ns / 1ps

module tb_irc_colour_code_stripper;

  localparam int POS_BITS     = ircs_pkg::POSITION_BITS_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 270;
  localparam logic [7:0] STYLE_LETTERS [7] = '{"b", "u", "r", "s", "c", "i", "C"};
  localparam ircs_pkg::res_t NO_RES = '0;

  // One row of the directed table: a beat, and optionally the result it must give
  typedef struct {
    logic [7:0]     b;
    logic           l;
    bit             typed;
    int             n;
    ircs_pkg::res_t want;
  } row_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [7:0]                        in_byte;
  logic                              in_last;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [7:0]                        out_byte;
  logic [ircs_pkg::OUT_POS_BITS-1:0] out_position;
  logic                              out_has_char;
  logic                              out_last;

  // Side information travelling with each beat of the directed table
  bit             row_typed = 1'b0;
  int             row_n = 0;
  ircs_pkg::res_t row_want = '0;

  // Stripper state as predicted
  logic                tilde_wait = 1'b0;
  logic [2:0]          phase = ircs_pkg::PH_IDLE;
  logic [POS_BITS-1:0] mark_pos = '0;
  logic [POS_BITS-1:0] next_pos = '0;

  ircs_pkg::res_t step_res [$];
  ircs_pkg::res_t pending_chars [$];
  row_t           script [$];
  logic [7:0]     text_q [$];
  int             mismatches = 0;
  int             cycles = 0;
  int             sink_hold = 0;

  irc_colour_code_stripper dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_position (out_position),
    .out_has_char (out_has_char),
    .out_last     (out_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit is_num(logic [7:0] c);
    return (c >= ircs_pkg::CH_DIG_LO) && (c <= ircs_pkg::CH_DIG_HI);
  endfunction

  function automatic bit is_style(logic [7:0] c);
    foreach (STYLE_LETTERS[i]) begin
      if (c == STYLE_LETTERS[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Queue one kept character for this beat; at most three per beat
  task automatic put_char(logic [7:0] c, logic [POS_BITS-1:0] p, logic h);
    ircs_pkg::res_t r;
    if (step_res.size() < ircs_pkg::RES_MAX) begin
      r.ch = c;
      r.pos = p;
      r.has_char = h;
      r.last = 1'b0;
      step_res.push_back(r);
    end
  endtask

  // Parse one byte after the front stage; loop while a byte must be looked at anew
  task automatic parse_char(logic [7:0] c);
    logic [POS_BITS-1:0] here;
    bit again;
    here = next_pos;
    if (next_pos != '1) next_pos++;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (phase)
        ircs_pkg::PH_TILDE: begin
          if (is_num(c)) phase = ircs_pkg::PH_DIG1;
          else if (is_style(c)) phase = ircs_pkg::PH_IDLE;
          else begin
            phase = ircs_pkg::PH_IDLE;
            again = 1'b1;
          end
        end
        ircs_pkg::PH_CTRL: begin
          if (is_num(c)) phase = ircs_pkg::PH_DIG1;
          else begin
            put_char(ircs_pkg::CH_CTRL, mark_pos, 1'b1);
            phase = ircs_pkg::PH_IDLE;
            again = 1'b1;
          end
        end
        ircs_pkg::PH_DIG1, ircs_pkg::PH_DIG2: begin
          if (phase == ircs_pkg::PH_DIG1 && is_num(c)) phase = ircs_pkg::PH_DIG2;
          else if (c == ircs_pkg::CH_COMMA) begin
            phase = ircs_pkg::PH_COMMA;
            mark_pos = here;
          end else begin
            phase = ircs_pkg::PH_IDLE;
            again = 1'b1;
          end
        end
        ircs_pkg::PH_COMMA: begin
          if (is_num(c)) phase = ircs_pkg::PH_CDIG1;
          else begin
            put_char(ircs_pkg::CH_COMMA, mark_pos, 1'b1);
            phase = ircs_pkg::PH_IDLE;
            again = 1'b1;
          end
        end
        ircs_pkg::PH_CDIG1: begin
          phase = ircs_pkg::PH_IDLE;
          if (!is_num(c)) again = 1'b1;
        end
        default: begin
          if (c == ircs_pkg::CH_TILDE) begin
            phase = ircs_pkg::PH_TILDE;
            mark_pos = here;
          end else if (c == ircs_pkg::CH_CTRL) begin
            phase = ircs_pkg::PH_CTRL;
            mark_pos = here;
          end else begin
            phase = ircs_pkg::PH_IDLE;
            put_char(c, here, 1'b1);
          end
        end
      endcase
    end
  endtask

  // Work out the results of one input beat, front stage first
  task automatic strip_step(logic [7:0] b, logic fin);
    step_res.delete();
    if (tilde_wait) begin
      tilde_wait = 1'b0;
      if (b != ircs_pkg::CH_S) begin
        parse_char(ircs_pkg::CH_TILDE);
        if (b == ircs_pkg::CH_TILDE) tilde_wait = 1'b1;
        else parse_char(b);
      end
    end else if (b == ircs_pkg::CH_TILDE) begin
      tilde_wait = 1'b1;
    end else begin
      parse_char(b);
    end
    // Settle lookahead at the end of the text, then start afresh
    if (fin) begin
      if (tilde_wait) begin
        tilde_wait = 1'b0;
        parse_char(ircs_pkg::CH_TILDE);
      end
      if (phase == ircs_pkg::PH_CTRL) put_char(ircs_pkg::CH_CTRL, mark_pos, 1'b1);
      else if (phase == ircs_pkg::PH_COMMA) put_char(ircs_pkg::CH_COMMA, mark_pos, 1'b1);
      if (step_res.size() == 0) put_char(8'h00, '0, 1'b0);
      step_res[step_res.size()-1].last = 1'b1;
      phase = ircs_pkg::PH_IDLE;
      mark_pos = '0;
      next_pos = '0;
    end
  endtask

  // Predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin
    ircs_pkg::res_t got;
    ircs_pkg::res_t want;
    if (rst_n && in_valid && !in_stall) begin
      strip_step(in_byte, in_last);
      if (row_typed) begin
        if (row_n != 0) pending_chars.push_back(row_want);
      end else begin
        foreach (step_res[i]) pending_chars.push_back(step_res[i]);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_byte, out_position, out_has_char, out_last};
      if (pending_chars.size() == 0) begin
        report("result beat with nothing expected", '0, 32'(got));
      end else begin
        want = pending_chars.pop_front();
        if (got.ch !== want.ch) report("out_byte", 32'(want.ch), 32'(got.ch));
        if (got.pos !== want.pos) report("out_position", 32'(want.pos), 32'(got.pos));
        if (got.has_char !== want.has_char) begin
          report("out_has_char", 32'(want.has_char), 32'(got.has_char));
        end
        if (got.last !== want.last) report("out_last", 32'(want.last), 32'(got.last));
      end
    end
  end

  // Pace the receiver: free runs, short stalls and the odd long one
  always @(posedge clk) begin
    int r;
    if (sink_hold > 0) begin
      sink_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall <= 1'b0;
        sink_hold = $urandom_range(0, 8);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        sink_hold = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        sink_hold = $urandom_range(5, 40);
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL irc_colour_code_stripper");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic row_t free_row(logic [7:0] c, logic fin);
    return '{b: c, l: fin, typed: 1'b0, n: 0, want: NO_RES};
  endfunction

  function automatic row_t fixed_row(logic [7:0] c, logic fin, int n, ircs_pkg::res_t want);
    return '{b: c, l: fin, typed: 1'b1, n: n, want: want};
  endfunction

  // Hold the beat until accepted, then idle or wait for every result to drain
  task automatic push_beat(row_t r, int gap, bit drain);
    in_valid <= 1'b1;
    in_byte <= r.b;
    in_last <= r.l;
    row_typed <= r.typed;
    row_n <= r.n;
    row_want <= r.want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap > 0 || drain) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        @(posedge clk);
        while (pending_chars.size() != 0) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(bit drain_after);
    row_t r;
    foreach (text_q[i]) begin
      r = free_row(text_q[i], i == text_q.size() - 1);
      push_beat(r, pick_gap(), drain_after && r.l);
    end
  endtask

  // Build one random text out of codes, pairs and plain characters
  task automatic build_text();
    int n_tok;
    int kind;
    logic [7:0] lead;
    text_q.delete();
    n_tok = $urandom_range(1, 6);
    repeat (n_tok) begin
      kind = $urandom_range(0, 99);
      lead = $urandom_range(0, 1) ? ircs_pkg::CH_TILDE : ircs_pkg::CH_CTRL;
      if (kind < 30) begin
        text_q.push_back(8'($urandom_range(32, 125)));
      end else if (kind < 40) begin
        text_q.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 65) begin
        text_q.push_back(lead);
        repeat ($urandom_range(1, 2)) begin
          text_q.push_back(8'(ircs_pkg::CH_DIG_LO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 1)) begin
          text_q.push_back(ircs_pkg::CH_COMMA);
          repeat ($urandom_range(0, 2)) begin
            text_q.push_back(8'(ircs_pkg::CH_DIG_LO + $urandom_range(0, 9)));
          end
        end
      end else if (kind < 77) begin
        text_q.push_back(ircs_pkg::CH_TILDE);
        text_q.push_back(STYLE_LETTERS[$urandom_range(0, 6)]);
      end else if (kind < 87) begin
        text_q.push_back(ircs_pkg::CH_TILDE);
        text_q.push_back(ircs_pkg::CH_S);
      end else if (kind < 94) begin
        text_q.push_back(lead);
      end else begin
        text_q.push_back(ircs_pkg::CH_COMMA);
      end
    end
  endtask

  task automatic load_script();
    // removed tilde-s pair between the byte extremes
    script.push_back(fixed_row(8'h01, 1'b0, 1, ircs_pkg::res_t'{8'h01, 16'd0, 1'b1, 1'b0}));
    script.push_back(fixed_row(ircs_pkg::CH_TILDE, 1'b0, 0, NO_RES));
    script.push_back(fixed_row(ircs_pkg::CH_S, 1'b0, 0, NO_RES));
    script.push_back(fixed_row(8'hFF, 1'b1, 1, ircs_pkg::res_t'{8'hFF, 16'd1, 1'b1, 1'b1}));
    // two digits on both sides of the comma: nothing prints, bare end beat
    script.push_back(fixed_row(ircs_pkg::CH_CTRL, 1'b0, 0, NO_RES));
    script.push_back(fixed_row("1", 1'b0, 0, NO_RES));
    script.push_back(fixed_row("2", 1'b0, 0, NO_RES));
    script.push_back(fixed_row(ircs_pkg::CH_COMMA, 1'b0, 0, NO_RES));
    script.push_back(fixed_row("3", 1'b0, 0, NO_RES));
    script.push_back(fixed_row("4", 1'b1, 1, ircs_pkg::res_t'{8'h00, 16'd0, 1'b0, 1'b1}));
    // tilde colour code with a comma and no digit after it
    script.push_back(free_row(ircs_pkg::CH_TILDE, 1'b0));
    script.push_back(free_row("5", 1'b0));
    script.push_back(free_row(ircs_pkg::CH_COMMA, 1'b0));
    script.push_back(free_row("x", 1'b1));
    // format letter skipped, then a tilde dropped alone
    script.push_back(free_row(ircs_pkg::CH_TILDE, 1'b0));
    script.push_back(free_row("b", 1'b0));
    script.push_back(free_row(ircs_pkg::CH_TILDE, 1'b0));
    script.push_back(free_row("z", 1'b1));
    // pair that only forms after the front stage removes one
    script.push_back(free_row(ircs_pkg::CH_TILDE, 1'b0));
    script.push_back(free_row(ircs_pkg::CH_TILDE, 1'b0));
    script.push_back(free_row(ircs_pkg::CH_S, 1'b0));
    script.push_back(free_row(ircs_pkg::CH_S, 1'b0));
    script.push_back(free_row("y", 1'b1));
    // pending comma flushed by a tilde held at the end
    script.push_back(free_row(ircs_pkg::CH_CTRL, 1'b0));
    script.push_back(free_row("7", 1'b0));
    script.push_back(free_row(ircs_pkg::CH_COMMA, 1'b0));
    script.push_back(free_row(ircs_pkg::CH_TILDE, 1'b1));
    // lone control byte at the end prints
    script.push_back(fixed_row(ircs_pkg::CH_CTRL, 1'b1, 1,
                               ircs_pkg::res_t'{ircs_pkg::CH_CTRL, 16'd0, 1'b1, 1'b1}));
  endtask

  initial begin
    int sent;
    int txt;
    bit drain_now;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_last = 1'b0;
    load_script();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, then hold off until it has all come back
    foreach (script[i]) push_beat(script[i], pick_gap(), i == script.size() - 1);

    // random texts, with the odd full drain
    sent = 0;
    txt = 0;
    while (sent < RANDOM_ITEMS) begin
      build_text();
      drain_now = (txt == 5) || ($urandom_range(0, 19) == 0);
      send_text(drain_now);
      sent += text_q.size();
      txt++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS irc_colour_code_stripper");
    end else begin
      $display("FAIL irc_colour_code_stripper");
    end
    $finish;
  end

endmodule

@@ irc_colour_code_stripper.f @@
+incdir+design
design/ircs_pkg.sv
design/ircs_step.sv
design/ircs_out_fifo.sv
design/irc_colour_code_stripper.sv
verif/tb_irc_colour_code_stripper.sv
